// File: hw/rtl/sync_header_frame_builder_xor_assert.svh
// Assertion macros for the frame builder.
`ifndef SYNC_HEADER_FRAME_BUILDER_XOR_ASSERT_SVH
`define SYNC_HEADER_FRAME_BUILDER_XOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define SHFB_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("frame builder check failed");
`define SHFB_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("frame builder check failed");
`else
`define SHFB_ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define SHFB_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif

`endif

// File: hw/rtl/shfb_pkg.sv
package shfb_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 4;
  localparam int NUM_SLOTS = 8;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] PAD_BYTE    = 8'h00;

  typedef logic [2:0] slot_t;

  localparam slot_t SLOT_SYNC_A  = 3'd0;
  localparam slot_t SLOT_SYNC_B  = 3'd1;
  localparam slot_t SLOT_LEN_HI  = 3'd2;
  localparam slot_t SLOT_LEN_LO  = 3'd3;
  localparam slot_t SLOT_TYPE    = 3'd4;
  localparam slot_t SLOT_PAYLOAD = 3'd5;
  localparam slot_t SLOT_PAD     = 3'd6;
  localparam slot_t SLOT_TRAILER = 3'd7;

  typedef struct packed {
    logic [15:0] frame_length;
    logic [7:0]  frame_type;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        first_of_frame;
    logic        last_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;
  } out_beat_t;

  typedef struct packed {
    logic [7:0]           len_hi;
    logic [7:0]           len_lo;
    logic [7:0]           frame_type;
    logic [7:0]           data_byte;
    logic [7:0]           trailer;
    logic [NUM_SLOTS-1:0] slots;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

endpackage

// File: hw/rtl/shfb_front.sv
module shfb_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  shfb_pkg::in_beat_t in_beat,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               q_full,
  output shfb_pkg::q_push_t  q_push
);
  import shfb_pkg::*;

  logic       checksum_mode_r;
  logic       checksum_mode_nxt;
  logic [7:0] running_xor_r;
  logic [7:0] running_xor_nxt;
  logic [7:0] xor_hdr;
  logic [7:0] xor_data;
  logic       accept;
  logic       has_work;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign has_work = in_beat.first_of_frame || in_beat.has_byte || in_beat.last_of_frame;

  always_comb begin
    xor_hdr = running_xor_r;
    if (in_beat.first_of_frame) begin
      xor_hdr = SYNC_FIRST ^ SYNC_SECOND ^ in_beat.frame_length[15:8] ^
                in_beat.frame_length[7:0] ^ in_beat.frame_type;
    end
    xor_data = in_beat.has_byte ? (xor_hdr ^ in_beat.data_byte) : xor_hdr;
  end

  always_comb begin
    running_xor_nxt = running_xor_r;
    if (accept) begin
      running_xor_nxt = in_beat.last_of_frame ? 8'h00 : xor_data;
    end
    checksum_mode_nxt = cfg_wr_en ? cfg_wr_data : checksum_mode_r;
  end

  always_comb begin
    q_push.valid          = accept && has_work;
    q_push.job.len_hi     = in_beat.frame_length[15:8];
    q_push.job.len_lo     = in_beat.frame_length[7:0];
    q_push.job.frame_type = in_beat.frame_type;
    q_push.job.data_byte  = in_beat.data_byte;
    q_push.job.trailer    = checksum_mode_r ? xor_data : PAD_BYTE;
    q_push.job.slots      = {in_beat.last_of_frame, in_beat.last_of_frame,
                             in_beat.has_byte, {5{in_beat.first_of_frame}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      checksum_mode_r <= 1'b0;
      running_xor_r   <= 8'h00;
    end else begin
      checksum_mode_r <= checksum_mode_nxt;
      running_xor_r   <= running_xor_nxt;
    end
  end

endmodule

// File: hw/rtl/shfb_queue.sv
module shfb_queue #(
  parameter int QUEUE_DEPTH = shfb_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  shfb_pkg::q_push_t q_push,
  input  logic              q_pop,
  output logic              q_full,
  output logic              q_valid,
  output shfb_pkg::job_t    q_head
);
  import shfb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_head  = entries[rd_ptr_r];
  assign do_push = q_push.valid && !q_full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr_r] <= q_push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: hw/rtl/shfb_back.sv
module shfb_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  shfb_pkg::job_t      q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output shfb_pkg::out_beat_t out_beat
);
  import shfb_pkg::*;

  logic [NUM_SLOTS-1:0] done_r;
  logic [NUM_SLOTS-1:0] done_nxt;
  logic [NUM_SLOTS-1:0] remaining;
  logic [NUM_SLOTS-1:0] slot_bit;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  out_beat_t            out_beat_r;
  out_beat_t            beat;
  slot_t                slot;
  logic                 found;
  logic                 emit;
  logic                 final_slot;

  assign remaining  = q_head.slots & ~done_r;
  assign slot_bit   = NUM_SLOTS'(1) << slot;
  assign final_slot = ((remaining & ~slot_bit) == '0);
  assign emit       = q_valid && (!out_valid_r || !out_stall);
  assign q_pop      = emit && final_slot;
  assign out_valid  = out_valid_r;
  assign out_beat   = out_beat_r;

  always_comb begin
    slot  = SLOT_SYNC_A;
    found = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (remaining[i] && !found) begin
        slot  = slot_t'(i);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    case (slot)
      SLOT_SYNC_A:  beat.out_byte = SYNC_FIRST;
      SLOT_SYNC_B:  beat.out_byte = SYNC_SECOND;
      SLOT_LEN_HI:  beat.out_byte = q_head.len_hi;
      SLOT_LEN_LO:  beat.out_byte = q_head.len_lo;
      SLOT_TYPE:    beat.out_byte = q_head.frame_type;
      SLOT_PAYLOAD: beat.out_byte = q_head.data_byte;
      SLOT_PAD:     beat.out_byte = PAD_BYTE;
      SLOT_TRAILER: beat.out_byte = q_head.trailer;
      default:      beat.out_byte = PAD_BYTE;
    endcase
    beat.last_of_run = final_slot;
    beat.frame_end   = (slot == SLOT_TRAILER);
  end

  always_comb begin
    done_nxt = done_r;
    if (q_pop) begin
      done_nxt = '0;
    end else if (emit) begin
      done_nxt = done_r | slot_bit;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_beat_r <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: hw/rtl/sync_header_frame_builder_xor.sv
// The first byte caused by an item passes the job queue entry, then the output register.
// The output side moves one byte per cycle unless out_stall holds it; an item producing k
// bytes holds the byte sequencer for all k, so unstalled payload-only items flow at one item per cycle.
// Input beats are taken while the job queue between front and back has a free entry.
// Reset (rst_n low at a clock edge) empties the queue and output stage, clears the running
// XOR and sets checksum mode to zero.
`include "sync_header_frame_builder_xor_assert.svh"

module sync_header_frame_builder_xor #(
  parameter int QUEUE_DEPTH = shfb_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  shfb_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output shfb_pkg::out_beat_t out_beat,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import shfb_pkg::*;

  q_push_t q_push;
  job_t    q_head;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;

  shfb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_beat     (in_beat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push)
  );

  shfb_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  shfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  `SHFB_ASSERT_NEXT(a_job_queued, clk, rst_n, q_push.valid, q_valid)
  `SHFB_ASSERT_IMPLIES(a_end_closes_run, clk, rst_n, out_valid && out_beat.frame_end, out_beat.last_of_run)
  `SHFB_ASSERT_IMPLIES(a_pop_has_job, clk, rst_n, q_pop, q_valid)

endmodule
